### hw/rtl/pr3d_pkg.sv
package pr3d_pkg;

   localparam int COORD_WIDTH     = 32;
   localparam int COEF_FRAC_BITS  = 16;
   localparam int COEF_WIDTH      = COEF_FRAC_BITS + 3;
   localparam int ANGLE_WIDTH     = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int NUM_COEFS       = 9;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANGLE_X = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANGLE_Y = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANGLE_Z = 2'd2;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [COEF_WIDTH-1:0]  coef_type;
   typedef logic [ANGLE_WIDTH-1:0]        angle_type;
   typedef coef_type                      coef_set_type [NUM_COEFS];

   typedef struct packed {
      logic                       we;
      logic [CSR_INDEX_WIDTH-1:0] index;
      angle_type                  data;
   } csr_wr_type;

endpackage

### hw/rtl/pr3d_req_if.sv
interface pr3d_req_if;
   import pr3d_pkg::*;

   logic      valid;
   logic      ready;
   coord_type px;
   coord_type py;
   coord_type pz;

   modport source (output valid, output px, output py, output pz, input ready);
   modport sink (input valid, input px, input py, input pz, output ready);
endinterface

### hw/rtl/pr3d_rsp_if.sv
interface pr3d_rsp_if;
   import pr3d_pkg::*;

   logic      valid;
   logic      ready;
   coord_type rx;
   coord_type ry;
   coord_type rz;

   modport source (output valid, output rx, output ry, output rz, input ready);
   modport sink (input valid, input rx, input ry, input rz, output ready);
endinterface

### hw/rtl/point_rotation_3d_core.sv
// Rotates a stream of Q15.16 points by R = Rz*Ry*Rx, one word per cycle while
// the response side takes words and no coefficient rebuild runs. Each word
// passes the input register, products, two adder stages, and rounding and
// saturation. Writing an angle rebuilds the nine Q2.16 coefficients in a
// shared sequencer; request ready stays low meanwhile, through a start step,
// the sine and cosine series per angle (multiply, reciprocal divide, fix-up,
// update a term) and the matrix products. After reset the matrix is identity.
module point_rotation_3d_core (
   input  logic                                     clock,
   input  logic                                     reset,
   pr3d_req_if.sink                                 req_ch,
   pr3d_rsp_if.source                               rsp_ch,
   input  logic                                     csr_we,
   input  logic [pr3d_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  pr3d_pkg::angle_type                      csr_wdata
);
   import pr3d_pkg::*;

   localparam int PROD_W = COORD_WIDTH + COEF_WIDTH;
   localparam int SUM_W  = PROD_W + 2;

   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   localparam sum_type HALF   = sum_type'(1) <<< (COEF_FRAC_BITS - 1);
   localparam sum_type SAT_HI = (sum_type'(1) <<< (COORD_WIDTH - 1)) - sum_type'(1);
   localparam sum_type SAT_LO = -(sum_type'(1) <<< (COORD_WIDTH - 1));

   csr_wr_type   csr_wr;
   coef_set_type coefs;
   logic         coef_ready;

   logic v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   logic en0, en1, en2, en3, en4;

   coord_type p_ff    [3];
   prod_type  prod_ff [3][3];
   sum_type   pair_ff [3];
   sum_type   part_ff [3];
   sum_type   sum_ff  [3];
   coord_type out_ff  [3];
   sum_type   shifted [3];

   assign csr_wr = '{we: csr_we, index: csr_index, data: csr_wdata};

   pr3d_coef_gen u_coef_gen (
      .clock  (clock),
      .reset  (reset),
      .csr_wr (csr_wr),
      .coefs  (coefs),
      .ready  (coef_ready)
   );

   assign en4 = !v4_ff || rsp_ch.ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign en0 = !v0_ff || en1;

   assign req_ch.ready = en0 && coef_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en0) v0_ff <= req_ch.valid && coef_ready;
         if (en1) v1_ff <= v0_ff;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         shifted[i] = sum_ff[i] >>> COEF_FRAC_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (en0) begin
         p_ff[0] <= req_ch.px;
         p_ff[1] <= req_ch.py;
         p_ff[2] <= req_ch.pz;
      end
      if (en1) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               prod_ff[i][j] <= prod_type'(coefs[i*3+j]) * prod_type'(p_ff[j]);
            end
         end
      end
      if (en2) begin
         for (int i = 0; i < 3; i++) begin
            pair_ff[i] <= sum_type'(prod_ff[i][0]) + sum_type'(prod_ff[i][1]);
            part_ff[i] <= sum_type'(prod_ff[i][2]) + HALF;
         end
      end
      if (en3) begin
         for (int i = 0; i < 3; i++) begin
            sum_ff[i] <= pair_ff[i] + part_ff[i];
         end
      end
      if (en4) begin
         for (int i = 0; i < 3; i++) begin
            if (shifted[i] > SAT_HI) begin
               out_ff[i] <= coord_type'(SAT_HI[COORD_WIDTH-1:0]);
            end else if (shifted[i] < SAT_LO) begin
               out_ff[i] <= coord_type'(SAT_LO[COORD_WIDTH-1:0]);
            end else begin
               out_ff[i] <= coord_type'(shifted[i][COORD_WIDTH-1:0]);
            end
         end
      end
   end

   assign rsp_ch.valid = v4_ff;
   assign rsp_ch.rx    = out_ff[0];
   assign rsp_ch.ry    = out_ff[1];
   assign rsp_ch.rz    = out_ff[2];

endmodule

### hw/rtl/pr3d_coef_gen.sv
module pr3d_coef_gen (
   input  logic                   clock,
   input  logic                   reset,
   input  pr3d_pkg::csr_wr_type   csr_wr,
   output pr3d_pkg::coef_set_type coefs,
   output logic                   ready
);
   import pr3d_pkg::*;

   localparam int Q      = 30;
   localparam int MAG_W  = Q + 1;
   localparam int TRIG_W = Q + 2;
   localparam int TH_W   = Q + 1;
   localparam int T2_W   = Q + 3;
   localparam int NUM_W  = Q + 3;
   localparam int DIV_W  = 10;
   localparam int RCP_W  = 32;
   localparam int RCP_SH = 33;
   localparam int RQ_W   = NUM_W + RCP_W;
   localparam int ACC_W  = TRIG_W + 2;
   localparam int RSH    = Q - COEF_FRAC_BITS;
   localparam int PC_W   = 5;

   localparam logic [63:0]      PI_Q48   = 64'h3243F6A8885A3;
   localparam logic [63:0]      HALF64   = 64'd1 << (Q - 1);
   localparam logic [63:0]      TH_RND   = 64'd1 << 32;
   localparam logic [63:0]      RCP_NUM  = 64'd1 << RCP_SH;
   localparam logic [MAG_W-1:0] ONE      = MAG_W'(1) << Q;
   localparam logic [ACC_W-1:0] C_RND    = (ACC_W'(1) << RSH) >> 1;
   localparam coef_type         COEF_ONE = coef_type'(1) <<< COEF_FRAC_BITS;

   typedef logic signed [TRIG_W-1:0] trig_type;
   typedef logic signed [ACC_W-1:0]  acc_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_TH, ST_T2, ST_HMUL, ST_RCP, ST_FIX, ST_HUPD, ST_S0, ST_PMUL, ST_POP,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      SRC_SX, SRC_CX, SRC_SY, SRC_CY, SRC_SZ, SRC_CZ, SRC_TMP, SRC_ONE
   } src_type;

   typedef enum logic [1:0] {
      K_TMP, K_ADD, K_SUB
   } kind_type;

   typedef struct packed {
      src_type  a;
      src_type  b;
      kind_type kind;
      logic     last;
   } uop_type;

   function automatic uop_type uop_at(input logic [PC_W-1:0] pc);
      uop_type u;
      u = '{a: SRC_ONE, b: SRC_ONE, kind: K_TMP, last: 1'b1};
      case (pc)
         5'd0:  u = '{a: SRC_CY,  b: SRC_CZ,  kind: K_ADD, last: 1'b1};
         5'd1:  u = '{a: SRC_CZ,  b: SRC_SX,  kind: K_TMP, last: 1'b0};
         5'd2:  u = '{a: SRC_TMP, b: SRC_SY,  kind: K_ADD, last: 1'b0};
         5'd3:  u = '{a: SRC_CX,  b: SRC_SZ,  kind: K_SUB, last: 1'b1};
         5'd4:  u = '{a: SRC_SX,  b: SRC_SZ,  kind: K_ADD, last: 1'b0};
         5'd5:  u = '{a: SRC_CX,  b: SRC_CZ,  kind: K_TMP, last: 1'b0};
         5'd6:  u = '{a: SRC_TMP, b: SRC_SY,  kind: K_ADD, last: 1'b1};
         5'd7:  u = '{a: SRC_CY,  b: SRC_SZ,  kind: K_ADD, last: 1'b1};
         5'd8:  u = '{a: SRC_CX,  b: SRC_CZ,  kind: K_ADD, last: 1'b0};
         5'd9:  u = '{a: SRC_SX,  b: SRC_SY,  kind: K_TMP, last: 1'b0};
         5'd10: u = '{a: SRC_TMP, b: SRC_SZ,  kind: K_ADD, last: 1'b1};
         5'd11: u = '{a: SRC_CX,  b: SRC_SY,  kind: K_TMP, last: 1'b0};
         5'd12: u = '{a: SRC_TMP, b: SRC_SZ,  kind: K_ADD, last: 1'b0};
         5'd13: u = '{a: SRC_CZ,  b: SRC_SX,  kind: K_SUB, last: 1'b1};
         5'd14: u = '{a: SRC_SY,  b: SRC_ONE, kind: K_SUB, last: 1'b1};
         5'd15: u = '{a: SRC_CY,  b: SRC_SX,  kind: K_ADD, last: 1'b1};
         5'd16: u = '{a: SRC_CX,  b: SRC_CY,  kind: K_ADD, last: 1'b1};
         default: u = '{a: SRC_ONE, b: SRC_ONE, kind: K_TMP, last: 1'b1};
      endcase
      return u;
   endfunction

   // floor(2^33 / d), clipped to 32 bits; the estimate is at most one low
   function automatic logic [RCP_W-1:0] recip(input logic [DIV_W-1:0] d);
      logic [RCP_W-1:0] m;
      case (d)
         10'd2:   m = '1;
         10'd6:   m = RCP_W'(RCP_NUM / 64'd6);
         10'd12:  m = RCP_W'(RCP_NUM / 64'd12);
         10'd20:  m = RCP_W'(RCP_NUM / 64'd20);
         10'd30:  m = RCP_W'(RCP_NUM / 64'd30);
         10'd42:  m = RCP_W'(RCP_NUM / 64'd42);
         10'd56:  m = RCP_W'(RCP_NUM / 64'd56);
         10'd72:  m = RCP_W'(RCP_NUM / 64'd72);
         10'd90:  m = RCP_W'(RCP_NUM / 64'd90);
         10'd110: m = RCP_W'(RCP_NUM / 64'd110);
         10'd132: m = RCP_W'(RCP_NUM / 64'd132);
         10'd156: m = RCP_W'(RCP_NUM / 64'd156);
         10'd182: m = RCP_W'(RCP_NUM / 64'd182);
         10'd210: m = RCP_W'(RCP_NUM / 64'd210);
         10'd240: m = RCP_W'(RCP_NUM / 64'd240);
         10'd272: m = RCP_W'(RCP_NUM / 64'd272);
         default: m = '0;
      endcase
      return m;
   endfunction

   state_type          state_ff;
   angle_type          angle_ff [3];
   coef_type           coef_ff [NUM_COEFS];
   logic               dirty_ff;
   logic [1:0]         ai_ff;
   logic [3:0]         k_ff;
   logic               hc_ff;
   logic [1:0]         quad_ff;
   logic [TH_W-1:0]    th_ff;
   logic [T2_W-1:0]    t2_ff;
   logic [MAG_W-1:0]   as_ff;
   logic [MAG_W-1:0]   ac_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [NUM_W-1:0]   quo_ff;
   trig_type           sin_ff [3];
   trig_type           cos_ff [3];
   logic [PC_W-1:0]    pc_ff;
   logic [3:0]         ci_ff;
   trig_type           prod_ff;
   trig_type           tmp_ff;
   acc_type            acc_ff;

   uop_type            uop;
   trig_type           opa;
   trig_type           opb;
   logic [MAG_W-1:0]   ma;
   logic [MAG_W-1:0]   mb;
   logic [MAG_W-1:0]   mq;
   trig_type           mulq;
   logic [63:0]        th_prod;
   logic [63:0]        sq_prod;
   logic [63:0]        h_prod;
   logic [63:0]        s_prod;
   logic [4:0]         two_k;
   logic [DIV_W-1:0]   divisor;
   logic [RCP_W-1:0]   rcp;
   logic [RQ_W-1:0]    rq_prod;
   logic [NUM_W-1:0]   qd_prod;
   logic [NUM_W-1:0]   q_rem;
   logic [MAG_W-1:0]   h_val;
   logic [MAG_W-1:0]   s0_mag;
   trig_type           s0;
   trig_type           c0;
   logic [ACC_W-1:0]   acc_mag;
   logic [ACC_W-1:0]   acc_rnd;
   coef_type           coef_new;

   function automatic trig_type pick(input src_type s, input trig_type sn [3],
                                     input trig_type cs [3], input trig_type t);
      trig_type v;
      case (s)
         SRC_SX:  v = sn[0];
         SRC_CX:  v = cs[0];
         SRC_SY:  v = sn[1];
         SRC_CY:  v = cs[1];
         SRC_SZ:  v = sn[2];
         SRC_CZ:  v = cs[2];
         SRC_TMP: v = t;
         default: v = trig_type'(ONE);
      endcase
      return v;
   endfunction

   always_comb begin
      uop  = uop_at(pc_ff);
      opa  = pick(uop.a, sin_ff, cos_ff, tmp_ff);
      opb  = pick(uop.b, sin_ff, cos_ff, tmp_ff);
      ma   = MAG_W'(opa[TRIG_W-1] ? -opa : opa);
      mb   = MAG_W'(opb[TRIG_W-1] ? -opb : opb);
      mq   = MAG_W'(((64'(ma) * 64'(mb)) + HALF64) >> Q);
      mulq = (opa[TRIG_W-1] != opb[TRIG_W-1]) ? -trig_type'(mq) : trig_type'(mq);

      th_prod = 64'(angle_ff[ai_ff][13:0]) * PI_Q48;
      sq_prod = 64'(th_ff) * 64'(th_ff);
      h_prod  = 64'(t2_ff) * 64'(hc_ff ? ac_ff : as_ff);
      s_prod  = 64'(th_ff) * 64'(as_ff);

      two_k   = {k_ff, 1'b0};
      divisor = hc_ff ? DIV_W'(two_k) * DIV_W'(two_k - 5'd1)
                      : DIV_W'(two_k) * DIV_W'(two_k + 5'd1);
      rcp     = recip(divisor);
      rq_prod = RQ_W'(num_ff) * RQ_W'(rcp);
      qd_prod = quo_ff * NUM_W'(divisor);
      q_rem   = num_ff - qd_prod;
      h_val   = (num_ff > NUM_W'(ONE)) ? '0 : MAG_W'(NUM_W'(ONE) - num_ff);

      s0_mag  = MAG_W'((s_prod + HALF64) >> Q);
      s0      = trig_type'(s0_mag);
      c0      = trig_type'(ac_ff);

      acc_mag  = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
      acc_rnd  = (acc_mag + C_RND) >> RSH;
      coef_new = acc_ff[ACC_W-1] ? -coef_type'(acc_rnd[COEF_WIDTH-1:0])
                                 : coef_type'(acc_rnd[COEF_WIDTH-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dirty_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            angle_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_COEFS; i++) begin
            coef_ff[i] <= (i == 0 || i == 4 || i == 8) ? COEF_ONE : '0;
         end
      end else if (csr_wr.we) begin
         if (csr_wr.index == CSR_ANGLE_X || csr_wr.index == CSR_ANGLE_Y ||
             csr_wr.index == CSR_ANGLE_Z) begin
            angle_ff[csr_wr.index] <= csr_wr.data;
            dirty_ff               <= 1'b1;
            state_ff               <= ST_IDLE;
         end
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (dirty_ff) begin
                  dirty_ff <= 1'b0;
                  ai_ff    <= 2'd0;
                  state_ff <= ST_TH;
               end
            end
            ST_TH: begin
               th_ff    <= TH_W'((th_prod + TH_RND) >> 33);
               quad_ff  <= angle_ff[ai_ff][15:14];
               state_ff <= ST_T2;
            end
            ST_T2: begin
               t2_ff    <= T2_W'((sq_prod + HALF64) >> Q);
               as_ff    <= ONE;
               ac_ff    <= ONE;
               k_ff     <= 4'd8;
               hc_ff    <= 1'b0;
               state_ff <= ST_HMUL;
            end
            ST_HMUL: begin
               num_ff   <= NUM_W'((h_prod + HALF64) >> Q);
               state_ff <= ST_RCP;
            end
            ST_RCP: begin
               quo_ff   <= NUM_W'(rq_prod >> RCP_SH);
               state_ff <= ST_FIX;
            end
            ST_FIX: begin
               num_ff   <= (q_rem >= NUM_W'(divisor)) ? quo_ff + NUM_W'(1) : quo_ff;
               state_ff <= ST_HUPD;
            end
            ST_HUPD: begin
               if (!hc_ff) begin
                  as_ff    <= h_val;
                  hc_ff    <= 1'b1;
                  state_ff <= ST_HMUL;
               end else begin
                  ac_ff <= h_val;
                  hc_ff <= 1'b0;
                  if (k_ff == 4'd1) begin
                     state_ff <= ST_S0;
                  end else begin
                     k_ff     <= k_ff - 4'd1;
                     state_ff <= ST_HMUL;
                  end
               end
            end
            ST_S0: begin
               case (quad_ff)
                  2'd0: begin sin_ff[ai_ff] <= s0;  cos_ff[ai_ff] <= c0;  end
                  2'd1: begin sin_ff[ai_ff] <= c0;  cos_ff[ai_ff] <= -s0; end
                  2'd2: begin sin_ff[ai_ff] <= -s0; cos_ff[ai_ff] <= -c0; end
                  default: begin sin_ff[ai_ff] <= -c0; cos_ff[ai_ff] <= s0; end
               endcase
               if (ai_ff == 2'd2) begin
                  pc_ff    <= '0;
                  ci_ff    <= '0;
                  acc_ff   <= '0;
                  state_ff <= ST_PMUL;
               end else begin
                  ai_ff    <= ai_ff + 2'd1;
                  state_ff <= ST_TH;
               end
            end
            ST_PMUL: begin
               prod_ff  <= mulq;
               state_ff <= ST_POP;
            end
            ST_POP: begin
               case (uop.kind)
                  K_TMP:   tmp_ff <= prod_ff;
                  K_ADD:   acc_ff <= acc_ff + acc_type'(prod_ff);
                  K_SUB:   acc_ff <= acc_ff - acc_type'(prod_ff);
                  default: tmp_ff <= prod_ff;
               endcase
               pc_ff    <= pc_ff + 1'b1;
               state_ff <= uop.last ? ST_EMIT : ST_PMUL;
            end
            ST_EMIT: begin
               coef_ff[ci_ff] <= coef_new;
               acc_ff         <= '0;
               if (ci_ff == 4'(NUM_COEFS - 1)) begin
                  state_ff <= ST_IDLE;
               end else begin
                  ci_ff    <= ci_ff + 4'd1;
                  state_ff <= ST_PMUL;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign coefs = coef_ff;
   assign ready = (state_ff == ST_IDLE) && !dirty_ff;

endmodule
